// ===== hdl/spo2_pkg.sv =====
package spo2_pkg;

   localparam int MAX_WINDOW = 1024;
   localparam int WIN_W      = 11;
   localparam int MEAN_W     = 34;
   localparam int ADDR_W     = 5;

   // register byte addresses
   localparam logic [ADDR_W-1:0] ADDR_WINDOW  = 5'd0;
   localparam logic [ADDR_W-1:0] ADDR_THRESH  = 5'd4;
   localparam logic [ADDR_W-1:0] ADDR_DC_COEF = 5'd8;
   localparam logic [ADDR_W-1:0] ADDR_SM_COEF = 5'd12;
   localparam logic [ADDR_W-1:0] ADDR_RELEASE = 5'd16;

   localparam logic [20:0] SLOPE_Q16 = 21'd1526989;
   localparam logic signed [63:0] INTERCEPT_Q32 = 64'sd469525824799;
   localparam logic [15:0] SPO2_RESET = 16'd24320;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_MEAN   = 13'b0000000000010,
      ST_ESET   = 13'b0000000000100,
      ST_ENERGY = 13'b0000000001000,
      ST_DECIDE = 13'b0000000010000,
      ST_SQRT   = 13'b0000000100000,
      ST_NORM   = 13'b0000001000000,
      ST_MUL    = 13'b0000010000000,
      ST_DSET   = 13'b0000100000000,
      ST_DIV    = 13'b0001000000000,
      ST_RAW    = 13'b0010000000000,
      ST_SMOOTH = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

endpackage

// ===== hdl/streaming_spo2_estimator_unit.sv =====
// Streaming SpO2 estimator.
// Request channel (req_valid/req_ready): one red/IR sample pair plus a
// millisecond time stamp. Response channel (rsp_valid/rsp_ready): exactly one
// response per request with finger presence, a new-estimate flag and the
// smoothed SpO2 value in signed Q8.8.
// Configuration goes through an APB-style port (psel/penable/pwrite, 4-byte
// register spacing, pready tied high); write it only while the block is idle.
// A request that does not close a window runs a 17-step DC mean multiply,
// a 27-step deviation square, the decision and the output.
// A request that closes a window with an estimate adds 32-step square roots,
// up to 8 normalize shifts, 32-step products, a 32-step restoring divide,
// a 21-step slope multiply, 17-step smoothing; saturation skips the divide.
// All arithmetic is shift-and-add, one multiplier bit or one root/quotient
// digit per cycle; one request is processed at a time.
// Reset restores the default register values, clears the means, energies and
// window count and sets the smoothed estimate to 95.0.
// A stalled receiver holds the response register; the next request is still
// taken and processed, and it waits at the end until the response is taken.
module streaming_spo2_estimator_unit
   import spo2_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [17:0]         req_red_sample,
   input  logic [17:0]         req_ir_sample,
   input  logic [31:0]         req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_finger_present,
   output logic                rsp_estimate_valid,
   output logic signed [15:0]  rsp_spo2_estimate,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // configuration
   logic [WIN_W-1:0] win_cfg_ff;
   logic [17:0]      thresh_ff;
   logic [15:0]      dc_coef_ff;
   logic [15:0]      sm_coef_ff;
   logic [31:0]      release_ff;

   // block state
   logic [WIN_W-1:0]  window_count_ff, window_count_in;
   logic [MEAN_W-1:0] red_mean_ff, red_mean_in, ir_mean_ff, ir_mean_in;
   logic [63:0]       red_energy_ff, red_energy_in, ir_energy_ff, ir_energy_in;
   logic [15:0]       smooth_ff, smooth_in;

   // working registers
   state_type         state_ff, state_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [17:0]       red_s_ff, red_s_in, ir_s_ff, ir_s_in;
   logic [31:0]       now_ff, now_in;
   logic              finger_ff, finger_in;
   logic              close_ff, close_in;
   logic              valid_ff, valid_in;
   logic [63:0]       acc_r_ff, acc_r_in, acc_i_ff, acc_i_in;
   logic [31:0]       mul1_ff, mul1_in, mul2_ff, mul2_in;
   logic [26:0]       d_r_ff, d_r_in, d_i_ff, d_i_in;
   logic [35:0]       rem_r_ff, rem_r_in, rem_i_ff, rem_i_in;
   logic [31:0]       root_r_ff, root_r_in, root_i_ff, root_i_in;
   logic [MEAN_W-1:0] nm_r_ff, nm_r_in, nm_i_ff, nm_i_in;
   logic [58:0]       div_rem_ff, div_rem_in;
   logic [15:0]       raw_ff, raw_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_finger_ff, rsp_finger_in;
   logic              rsp_est_ff, rsp_est_in;
   logic [15:0]       rsp_spo2_ff, rsp_spo2_in;

   logic              cfg_wr;
   logic [WIN_W-1:0]  win_eff;
   logic [WIN_W-1:0]  wc_next;

   // combinational helpers
   logic [MEAN_W-1:0] x_r, x_i, mag_r, mag_i;
   logic [34:0]       rnd_r, rnd_i;
   logic [63:0]       step_r, step_i, fin_r, fin_i;
   logic [64:0]       esum_r, esum_i;
   logic [35:0]       sq_t_r, sq_t_i, sq_trial_r, sq_trial_i;
   logic [57:0]       den;
   logic [58:0]       div_t;
   logic signed [63:0] v_raw, q_raw;
   logic [16:0]       k17, kk17, c17, cc17;

   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (paddr)
         ADDR_WINDOW:  prdata = {21'd0, win_cfg_ff};
         ADDR_THRESH:  prdata = {14'd0, thresh_ff};
         ADDR_DC_COEF: prdata = {16'd0, dc_coef_ff};
         ADDR_SM_COEF: prdata = {16'd0, sm_coef_ff};
         ADDR_RELEASE: prdata = release_ff;
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= WIN_W'(100);
         thresh_ff  <= 18'd30000;
         dc_coef_ff <= 16'd62259;
         sm_coef_ff <= 16'd45875;
         release_ff <= 32'd1000;
      end else if (cfg_wr) begin
         unique case (paddr)
            ADDR_WINDOW:  win_cfg_ff <= pwdata[WIN_W-1:0];
            ADDR_THRESH:  thresh_ff  <= pwdata[17:0];
            ADDR_DC_COEF: dc_coef_ff <= pwdata[15:0];
            ADDR_SM_COEF: sm_coef_ff <= pwdata[15:0];
            ADDR_RELEASE: release_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // clamp the window length into one..MAX_WINDOW
   always_comb begin
      priority if (win_cfg_ff == '0) win_eff = WIN_W'(1);
      else if (win_cfg_ff > WIN_W'(MAX_WINDOW)) win_eff = WIN_W'(MAX_WINDOW);
      else win_eff = win_cfg_ff;
   end
   assign wc_next = window_count_ff + WIN_W'(1);

   assign c17  = {1'b0, dc_coef_ff};
   assign cc17 = 17'd65536 - c17;
   assign k17  = {1'b0, sm_coef_ff};
   assign kk17 = 17'd65536 - k17;

   assign x_r   = {red_s_ff, 16'd0};
   assign x_i   = {ir_s_ff, 16'd0};
   assign mag_r = (x_r >= red_mean_ff) ? x_r - red_mean_ff : red_mean_ff - x_r;
   assign mag_i = (x_i >= ir_mean_ff) ? x_i - ir_mean_ff : ir_mean_ff - x_i;
   assign rnd_r = {1'b0, mag_r} + 35'd128;
   assign rnd_i = {1'b0, mag_i} + 35'd128;

   assign sq_t_r     = {rem_r_ff[33:0], acc_r_ff[63:62]};
   assign sq_t_i     = {rem_i_ff[33:0], acc_i_ff[63:62]};
   assign sq_trial_r = {2'b00, root_r_ff, 2'b01};
   assign sq_trial_i = {2'b00, root_i_ff, 2'b01};

   assign den   = acc_i_ff[57:0];
   assign div_t = {div_rem_ff[57:0], root_i_ff[31]};

   // datapath step for each state
   always_comb begin
      step_r = '0;
      step_i = '0;
      unique case (state_ff)
         ST_MEAN: begin
            step_r = {acc_r_ff[62:0], 1'b0}
                   + (mul1_ff[31] ? {30'd0, red_mean_ff} : 64'd0)
                   + (mul2_ff[31] ? {30'd0, x_r} : 64'd0);
            step_i = {acc_i_ff[62:0], 1'b0}
                   + (mul1_ff[31] ? {30'd0, ir_mean_ff} : 64'd0)
                   + (mul2_ff[31] ? {30'd0, x_i} : 64'd0);
         end
         ST_ENERGY: begin
            step_r = {acc_r_ff[62:0], 1'b0} + (mul1_ff[31] ? {37'd0, d_r_ff} : 64'd0);
            step_i = {acc_i_ff[62:0], 1'b0} + (mul2_ff[31] ? {37'd0, d_i_ff} : 64'd0);
         end
         ST_MUL: begin
            step_r = {acc_r_ff[62:0], 1'b0}
                   + (root_r_ff[31] ? {38'd0, nm_i_ff[25:0]} : 64'd0);
            step_i = {acc_i_ff[62:0], 1'b0}
                   + (root_i_ff[31] ? {38'd0, nm_r_ff[25:0]} : 64'd0);
         end
         ST_RAW: begin
            step_r = {acc_r_ff[62:0], 1'b0} + (mul1_ff[31] ? {32'd0, root_r_ff} : 64'd0);
         end
         ST_SMOOTH: begin
            step_i = {acc_i_ff[62:0], 1'b0}
                   + (mul1_ff[31] ? {{48{smooth_ff[15]}}, smooth_ff} : 64'd0)
                   + (mul2_ff[31] ? {{48{raw_ff[15]}}, raw_ff} : 64'd0);
         end
         default: ;
      endcase
   end

   assign fin_r  = step_r + 64'd32768;
   assign fin_i  = step_i + 64'd32768;
   assign esum_r = {1'b0, red_energy_ff} + {1'b0, step_r};
   assign esum_i = {1'b0, ir_energy_ff} + {1'b0, step_i};
   assign v_raw  = INTERCEPT_Q32 - $signed(step_r);
   assign q_raw  = (v_raw + 64'sd8388608) >>> 24;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff - 6'd1;
      window_count_in = window_count_ff;
      red_mean_in     = red_mean_ff;
      ir_mean_in      = ir_mean_ff;
      red_energy_in   = red_energy_ff;
      ir_energy_in    = ir_energy_ff;
      smooth_in       = smooth_ff;
      red_s_in        = red_s_ff;
      ir_s_in         = ir_s_ff;
      now_in          = now_ff;
      finger_in       = finger_ff;
      close_in        = close_ff;
      valid_in        = valid_ff;
      acc_r_in        = acc_r_ff;
      acc_i_in        = acc_i_ff;
      mul1_in         = {mul1_ff[30:0], 1'b0};
      mul2_in         = {mul2_ff[30:0], 1'b0};
      d_r_in          = d_r_ff;
      d_i_in          = d_i_ff;
      rem_r_in        = rem_r_ff;
      rem_i_in        = rem_i_ff;
      root_r_in       = root_r_ff;
      root_i_in       = root_i_ff;
      nm_r_in         = nm_r_ff;
      nm_i_in         = nm_i_ff;
      div_rem_in      = div_rem_ff;
      raw_in          = raw_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_finger_in   = rsp_finger_ff;
      rsp_est_in      = rsp_est_ff;
      rsp_spo2_in     = rsp_spo2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = cnt_ff;
            if (req_valid) begin
               // take the request and advance the window count
               red_s_in  = req_red_sample;
               ir_s_in   = req_ir_sample;
               now_in    = req_now_ms;
               finger_in = (req_ir_sample >= thresh_ff);
               close_in  = (wc_next >= win_eff);
               window_count_in = (wc_next >= win_eff) ? '0 : wc_next;
               acc_r_in  = '0;
               acc_i_in  = '0;
               mul1_in   = {c17, 15'd0};
               mul2_in   = {cc17, 15'd0};
               cnt_in    = 6'd16;
               state_in  = ST_MEAN;
            end
         end
         ST_MEAN: begin
            acc_r_in = step_r;
            acc_i_in = step_i;
            if (cnt_ff == 6'd0) begin
               red_mean_in = fin_r[MEAN_W+15:16];
               ir_mean_in  = fin_i[MEAN_W+15:16];
               state_in    = ST_ESET;
            end
         end
         ST_ESET: begin
            d_r_in   = rnd_r[34:8];
            d_i_in   = rnd_i[34:8];
            mul1_in  = {rnd_r[34:8], 5'd0};
            mul2_in  = {rnd_i[34:8], 5'd0};
            acc_r_in = '0;
            acc_i_in = '0;
            cnt_in   = 6'd26;
            state_in = ST_ENERGY;
         end
         ST_ENERGY: begin
            acc_r_in = step_r;
            acc_i_in = step_i;
            if (cnt_ff == 6'd0) begin
               // saturate the energy sums
               red_energy_in = esum_r[64] ? '1 : esum_r[63:0];
               ir_energy_in  = esum_i[64] ? '1 : esum_i[63:0];
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            valid_in = 1'b0;
            state_in = ST_DONE;
            if (close_ff) begin
               red_energy_in = '0;
               ir_energy_in  = '0;
               if (now_ff >= release_ff && ir_mean_ff != '0 && ir_energy_ff != '0) begin
                  acc_r_in  = red_energy_ff;
                  acc_i_in  = ir_energy_ff;
                  rem_r_in  = '0;
                  rem_i_in  = '0;
                  root_r_in = '0;
                  root_i_in = '0;
                  nm_r_in   = red_mean_ff;
                  nm_i_in   = ir_mean_ff;
                  cnt_in    = 6'd31;
                  state_in  = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            // one root digit per cycle in each lane
            acc_r_in = {acc_r_ff[61:0], 2'b00};
            acc_i_in = {acc_i_ff[61:0], 2'b00};
            if (sq_t_r >= sq_trial_r) begin
               rem_r_in  = sq_t_r - sq_trial_r;
               root_r_in = {root_r_ff[30:0], 1'b1};
            end else begin
               rem_r_in  = sq_t_r;
               root_r_in = {root_r_ff[30:0], 1'b0};
            end
            if (sq_t_i >= sq_trial_i) begin
               rem_i_in  = sq_t_i - sq_trial_i;
               root_i_in = {root_i_ff[30:0], 1'b1};
            end else begin
               rem_i_in  = sq_t_i;
               root_i_in = {root_i_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd0) state_in = ST_NORM;
         end
         ST_NORM: begin
            cnt_in = cnt_ff;
            if ((nm_r_ff[MEAN_W-1:26] | nm_i_ff[MEAN_W-1:26]) != '0) begin
               nm_r_in = nm_r_ff >> 1;
               nm_i_in = nm_i_ff >> 1;
            end else begin
               acc_r_in = '0;
               acc_i_in = '0;
               cnt_in   = 6'd31;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_r_in  = step_r;
            acc_i_in  = step_i;
            root_r_in = {root_r_ff[30:0], 1'b0};
            root_i_in = {root_i_ff[30:0], 1'b0};
            if (cnt_ff == 6'd0) state_in = ST_DSET;
         end
         ST_DSET: begin
            // saturate when the integer part of the ratio reaches 65536
            if (den == '0 || {16'd0, acc_r_ff[57:0]} >= {den, 16'd0}) begin
               root_r_in = '1;
               mul1_in   = {SLOPE_Q16, 11'd0};
               acc_r_in  = '0;
               cnt_in    = 6'd20;
               state_in  = ST_RAW;
            end else begin
               div_rem_in = {17'd0, acc_r_ff[57:16]};
               root_i_in  = {acc_r_ff[15:0], 16'd0};
               root_r_in  = '0;
               cnt_in     = 6'd31;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            root_i_in = {root_i_ff[30:0], 1'b0};
            if (div_t >= {1'b0, den}) begin
               div_rem_in = div_t - {1'b0, den};
               root_r_in  = {root_r_ff[30:0], 1'b1};
            end else begin
               div_rem_in = div_t;
               root_r_in  = {root_r_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               mul1_in  = {SLOPE_Q16, 11'd0};
               acc_r_in = '0;
               cnt_in   = 6'd20;
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            acc_r_in = step_r;
            if (cnt_ff == 6'd0) begin
               priority if (q_raw < -64'sd32768) raw_in = 16'h8000;
               else if (q_raw > 64'sd32767) raw_in = 16'h7FFF;
               else raw_in = q_raw[15:0];
               mul1_in  = {k17, 15'd0};
               mul2_in  = {kk17, 15'd0};
               acc_i_in = '0;
               cnt_in   = 6'd16;
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            acc_i_in = step_i;
            if (cnt_ff == 6'd0) begin
               smooth_in = fin_i[31:16];
               valid_in  = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            cnt_in = cnt_ff;
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_finger_in = finger_ff;
               rsp_est_in    = valid_ff;
               rsp_spo2_in   = smooth_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         window_count_ff <= '0;
         red_mean_ff     <= '0;
         ir_mean_ff      <= '0;
         red_energy_ff   <= '0;
         ir_energy_ff    <= '0;
         smooth_ff       <= SPO2_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         window_count_ff <= window_count_in;
         red_mean_ff     <= red_mean_in;
         ir_mean_ff      <= ir_mean_in;
         red_energy_ff   <= red_energy_in;
         ir_energy_ff    <= ir_energy_in;
         smooth_ff       <= smooth_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_s_ff      <= red_s_in;
      ir_s_ff       <= ir_s_in;
      now_ff        <= now_in;
      finger_ff     <= finger_in;
      close_ff      <= close_in;
      valid_ff      <= valid_in;
      acc_r_ff      <= acc_r_in;
      acc_i_ff      <= acc_i_in;
      mul1_ff       <= mul1_in;
      mul2_ff       <= mul2_in;
      d_r_ff        <= d_r_in;
      d_i_ff        <= d_i_in;
      rem_r_ff      <= rem_r_in;
      rem_i_ff      <= rem_i_in;
      root_r_ff     <= root_r_in;
      root_i_ff     <= root_i_in;
      nm_r_ff       <= nm_r_in;
      nm_i_ff       <= nm_i_in;
      div_rem_ff    <= div_rem_in;
      raw_ff        <= raw_in;
      rsp_finger_ff <= rsp_finger_in;
      rsp_est_ff    <= rsp_est_in;
      rsp_spo2_ff   <= rsp_spo2_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_finger_present = rsp_finger_ff;
   assign rsp_estimate_valid = rsp_est_ff;
   assign rsp_spo2_estimate  = $signed(rsp_spo2_ff);

`ifndef SYNTHESIS
   // a closing window always leaves the energies cleared
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && close_ff) |=> (red_energy_ff == '0 && ir_energy_ff == '0))
      else $error("energies not cleared at window close");

   // the window count never reaches the longest window
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      window_count_ff < WIN_W'(MAX_WINDOW))
      else $error("window count out of range");

   // a response is loaded only from the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) && state_ff != ST_DONE |=> !rsp_valid_ff)
      else $error("response appeared without a finished request");
`endif

endmodule
